// File: rtl/glu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GCD/LCM unit package
// Shared widths, microcode encodings, control structs and the program store.
// ----------------------------------------------------------------------------
package glu_pkg;

  localparam int unsigned OperandWidth = 32;
  localparam int unsigned FieldWidth   = 32;
  localparam int unsigned ResultWidth  = 64;
  localparam int unsigned InDataWidth  = 2 * FieldWidth;
  localparam int unsigned ProdWidth    = 2 * OperandWidth;
  localparam int unsigned CountWidth   = $clog2(OperandWidth + 1);
  localparam int unsigned StepWidth    = 4;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_DIV_EUCLID,
    OP_SHIFT,
    OP_DIV_LCM,
    OP_MUL,
    OP_SET_GCD,
    OP_SET_LCM,
    OP_SET_ERR,
    OP_EMIT
  } glu_op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_START,
    COND_B_ZERO,
    COND_DIV_BUSY,
    COND_REM_ZERO,
    COND_IS_GCD,
    COND_OUT_FULL
  } glu_cond_e;

  typedef struct packed {
    glu_op_e                op;
    glu_cond_e              cond;
    logic [StepWidth-1:0]   target;
  } glu_uword_t;

  typedef struct packed {
    logic    load;
    glu_op_e op;
  } glu_ctrl_t;

  typedef struct packed {
    logic b_zero;
    logic div_busy;
    logic rem_zero;
    logic is_gcd;
    logic out_full;
  } glu_status_t;

  localparam logic [StepWidth-1:0] STEP_IDLE     = 4'd0;
  localparam logic [StepWidth-1:0] STEP_CHECK    = 4'd1;
  localparam logic [StepWidth-1:0] STEP_EUCLID   = 4'd2;
  localparam logic [StepWidth-1:0] STEP_EWAIT    = 4'd3;
  localparam logic [StepWidth-1:0] STEP_RTEST    = 4'd4;
  localparam logic [StepWidth-1:0] STEP_SHIFT    = 4'd5;
  localparam logic [StepWidth-1:0] STEP_OPTEST   = 4'd6;
  localparam logic [StepWidth-1:0] STEP_LDIV     = 4'd7;
  localparam logic [StepWidth-1:0] STEP_LWAIT    = 4'd8;
  localparam logic [StepWidth-1:0] STEP_MUL      = 4'd9;
  localparam logic [StepWidth-1:0] STEP_SETGCD   = 4'd10;
  localparam logic [StepWidth-1:0] STEP_SETLCM   = 4'd11;
  localparam logic [StepWidth-1:0] STEP_OUTWAIT  = 4'd12;
  localparam logic [StepWidth-1:0] STEP_EMIT     = 4'd13;
  localparam logic [StepWidth-1:0] STEP_ERR      = 4'd14;

  function automatic glu_uword_t glu_rom(input logic [StepWidth-1:0] addr);
    glu_uword_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_IDLE};
    case (addr)
      STEP_IDLE:    w = '{op: OP_NOP,        cond: COND_NO_START, target: STEP_IDLE};
      STEP_CHECK:   w = '{op: OP_NOP,        cond: COND_B_ZERO,   target: STEP_ERR};
      STEP_EUCLID:  w = '{op: OP_DIV_EUCLID, cond: COND_NEVER,    target: STEP_IDLE};
      STEP_EWAIT:   w = '{op: OP_NOP,        cond: COND_DIV_BUSY, target: STEP_EWAIT};
      STEP_RTEST:   w = '{op: OP_NOP,        cond: COND_REM_ZERO, target: STEP_OPTEST};
      STEP_SHIFT:   w = '{op: OP_SHIFT,      cond: COND_ALWAYS,   target: STEP_EUCLID};
      STEP_OPTEST:  w = '{op: OP_NOP,        cond: COND_IS_GCD,   target: STEP_SETGCD};
      STEP_LDIV:    w = '{op: OP_DIV_LCM,    cond: COND_NEVER,    target: STEP_IDLE};
      STEP_LWAIT:   w = '{op: OP_NOP,        cond: COND_DIV_BUSY, target: STEP_LWAIT};
      STEP_MUL:     w = '{op: OP_MUL,        cond: COND_ALWAYS,   target: STEP_SETLCM};
      STEP_SETGCD:  w = '{op: OP_SET_GCD,    cond: COND_ALWAYS,   target: STEP_OUTWAIT};
      STEP_SETLCM:  w = '{op: OP_SET_LCM,    cond: COND_NEVER,    target: STEP_IDLE};
      STEP_OUTWAIT: w = '{op: OP_NOP,        cond: COND_OUT_FULL, target: STEP_OUTWAIT};
      STEP_EMIT:    w = '{op: OP_EMIT,       cond: COND_ALWAYS,   target: STEP_IDLE};
      STEP_ERR:     w = '{op: OP_SET_ERR,    cond: COND_ALWAYS,   target: STEP_OUTWAIT};
      default:      w = '{op: OP_NOP,        cond: COND_ALWAYS,   target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/glu_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GCD/LCM unit divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module glu_divider (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [glu_pkg::OperandWidth-1:0]   dividend_i,
  input  logic [glu_pkg::OperandWidth-1:0]   divisor_i,
  output logic                               busy_o,
  output logic [glu_pkg::OperandWidth-1:0]   quotient_o,
  output logic [glu_pkg::OperandWidth-1:0]   remainder_o
);
  import glu_pkg::*;

  logic [CountWidth-1:0]   cnt_q, cnt_d;
  logic [OperandWidth-1:0] rem_q, rem_d;
  logic [OperandWidth-1:0] quo_q, quo_d;
  logic [OperandWidth-1:0] dsr_q, dsr_d;
  logic [OperandWidth:0]   trial;

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dsr_d = dsr_q;
    trial = {rem_q, quo_q[OperandWidth-1]} - {1'b0, dsr_q};
    if (start_i) begin
      cnt_d = CountWidth'(OperandWidth);
      rem_d = '0;
      quo_d = dividend_i;
      dsr_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (!trial[OperandWidth]) begin
        rem_d = trial[OperandWidth-1:0];
        quo_d = {quo_q[OperandWidth-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[OperandWidth-2:0], quo_q[OperandWidth-1]};
        quo_d = {quo_q[OperandWidth-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign busy_o      = (cnt_q != '0);
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// File: rtl/glu_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GCD/LCM unit sequencer
// Step counter over the microcode store with conditional jumps.
// ----------------------------------------------------------------------------
module glu_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  glu_pkg::glu_status_t status_i,
  output glu_pkg::glu_ctrl_t   ctrl_o,
  output logic                 ready_o
);
  import glu_pkg::*;

  logic [StepWidth-1:0] pc_q, pc_d;
  glu_uword_t           uword;
  logic                 take;

  always_comb begin
    uword = glu_rom(pc_q);
    case (uword.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_START: take = !start_i;
      COND_B_ZERO:   take = status_i.b_zero;
      COND_DIV_BUSY: take = status_i.div_busy;
      COND_REM_ZERO: take = status_i.rem_zero;
      COND_IS_GCD:   take = status_i.is_gcd;
      COND_OUT_FULL: take = status_i.out_full;
      default:       take = 1'b1;
    endcase
    pc_d = take ? uword.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ready_o     = (pc_q == STEP_IDLE);
  assign ctrl_o.load = (pc_q == STEP_IDLE) && start_i;
  assign ctrl_o.op   = uword.op;

endmodule

// File: rtl/glu_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GCD/LCM unit datapath
// Operand magnitudes and signs, shared divider, multiplier and output word.
// ----------------------------------------------------------------------------
module glu_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  glu_pkg::glu_ctrl_t                 ctrl_i,
  input  logic                               opcode_i,
  input  logic [glu_pkg::InDataWidth-1:0]    operands_i,
  output glu_pkg::glu_status_t               status_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [glu_pkg::ResultWidth-1:0]    result_o,
  output logic                               zero_divisor_o
);
  import glu_pkg::*;

  logic [OperandWidth-1:0] a_raw, b_raw, a_abs, b_abs;
  logic [OperandWidth-1:0] num_q, den_q, amag_q, bmag_q;
  logic                    num_neg_q, den_neg_q, aneg_q, bneg_q, lcm_q;
  logic [ProdWidth-1:0]    prod_q;
  logic [ResultWidth-1:0]  res_q, gcd_ext, prod_ext;
  logic                    err_q;
  logic                    div_start, div_busy;
  logic [OperandWidth-1:0] div_dividend, div_quot, div_rem;
  logic                    ovalid_q;
  logic [ResultWidth-1:0]  odata_q;
  logic                    ouser_q;

  assign a_raw = operands_i[OperandWidth-1:0];
  assign b_raw = operands_i[FieldWidth+OperandWidth-1:FieldWidth];
  assign a_abs = a_raw[OperandWidth-1] ? (~a_raw + 1'b1) : a_raw;
  assign b_abs = b_raw[OperandWidth-1] ? (~b_raw + 1'b1) : b_raw;

  assign div_start    = (ctrl_i.op == OP_DIV_EUCLID) || (ctrl_i.op == OP_DIV_LCM);
  assign div_dividend = (ctrl_i.op == OP_DIV_LCM) ? amag_q : num_q;

  glu_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (den_q),
    .busy_o      (div_busy),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  assign gcd_ext  = ResultWidth'(den_q);
  assign prod_ext = ResultWidth'(prod_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      num_q     <= a_abs;
      num_neg_q <= a_raw[OperandWidth-1];
      den_q     <= b_abs;
      den_neg_q <= b_raw[OperandWidth-1];
      amag_q    <= a_abs;
      aneg_q    <= a_raw[OperandWidth-1];
      bmag_q    <= b_abs;
      bneg_q    <= b_raw[OperandWidth-1];
      lcm_q     <= opcode_i;
    end else begin
      case (ctrl_i.op)
        OP_SHIFT: begin
          num_q     <= den_q;
          num_neg_q <= den_neg_q;
          den_q     <= div_rem;
          den_neg_q <= num_neg_q;
        end
        OP_MUL: begin
          prod_q <= ProdWidth'(div_quot) * ProdWidth'(bmag_q);
        end
        OP_SET_GCD: begin
          res_q <= den_neg_q ? (ResultWidth'(0) - gcd_ext) : gcd_ext;
          err_q <= 1'b0;
        end
        OP_SET_LCM: begin
          res_q <= (aneg_q ^ bneg_q ^ den_neg_q) ? (ResultWidth'(0) - prod_ext) : prod_ext;
          err_q <= 1'b0;
        end
        OP_SET_ERR: begin
          res_q <= '0;
          err_q <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (ctrl_i.op == OP_EMIT) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_EMIT) begin
      odata_q <= res_q;
      ouser_q <= err_q;
    end
  end

  assign status_o.b_zero   = (den_q == '0);
  assign status_o.div_busy = div_busy;
  assign status_o.rem_zero = (div_rem == '0);
  assign status_o.is_gcd   = !lcm_q;
  assign status_o.out_full = ovalid_q;

  assign out_valid_o    = ovalid_q;
  assign result_o       = odata_q;
  assign zero_divisor_o = ouser_q;

endmodule

// File: rtl/gcd_lcm_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GCD/LCM unit core
// Signed Euclidean GCD, or LCM as (|a| / gcd) * |b| with the sign restored.
// ----------------------------------------------------------------------------
// One word is processed at a time; the next is accepted once the result has
// moved into the output register. A GCD word takes one division per Euclid
// step on the shared one-bit-per-cycle restoring divider; up to 45 steps are
// needed. LCM adds one more division and a multiply; a zero divisor is flagged
// without any division.
// Reset clears the step counter, the divider counter and the output valid.
module gcd_lcm_unit_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [glu_pkg::InDataWidth-1:0]   s_axis_tdata,  // operand_a, operand_b
  input  logic                              s_axis_tuser,  // opcode
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [glu_pkg::ResultWidth-1:0]   m_axis_tdata,  // result
  output logic                              m_axis_tuser   // zero_divisor
);
  import glu_pkg::*;

  glu_ctrl_t   ctrl;
  glu_status_t status;

  glu_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (s_axis_tvalid),
    .status_i (status),
    .ctrl_o   (ctrl),
    .ready_o  (s_axis_tready)
  );

  glu_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .opcode_i       (s_axis_tuser),
    .operands_i     (s_axis_tdata),
    .status_o       (status),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .result_o       (m_axis_tdata),
    .zero_divisor_o (m_axis_tuser)
  );

endmodule
